FILE: rtl/qoi_image_encoder_defines.svh
// Assertion macros for the QOI encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef QOI_IMAGE_ENCODER_DEFINES_SVH
`define QOI_IMAGE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define QIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qie assertion failed");
// Next-cycle implication.
`define QIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qie assertion failed");
`else
`define QIE_ASSERT_IMP(lbl, ante, cons)
`define QIE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/qie_pkg.sv
// Shared types, opcodes and helper functions for the QOI encoder.
// No dependencies.
package qie_pkg;

  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned MAX_BYTES  = 6;
  localparam int unsigned OPS_MAX    = 5;
  localparam int unsigned CNT_W      = 3;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [5:0] RUN_LIMIT = 6'd62;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t BLACK_PX = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  typedef struct packed {
    pixel_t px;
    logic   sof;
    logic   eof;
  } pix_item_t;

  // Bytes one pixel produces, in stream order, plus how many are used.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } code_set_t;

  // History update from the encode stage.
  typedef struct packed {
    logic               we;
    logic               clr;
    logic [HIST_AW-1:0] addr;
    pixel_t             data;
  } hist_wr_t;

  // Index hash (r*3 + g*5 + b*7 + a*11) mod 64; only the low 6 bits matter.
  function automatic logic [HIST_AW-1:0] qie_hash(pixel_t p);
    logic [HIST_AW-1:0] r6, g6, b6, a6;
    r6 = p.r[HIST_AW-1:0];
    g6 = p.g[HIST_AW-1:0];
    b6 = p.b[HIST_AW-1:0];
    a6 = p.a[HIST_AW-1:0];
    return r6 * 6'd3 + g6 * 6'd5 + b6 * 6'd7 + a6 * 6'd11;
  endfunction

  // Run opcode for a run of len pixels (len >= 1).
  function automatic logic [7:0] run_byte(logic [5:0] len);
    return OP_RUN | {2'b00, 6'(len - 6'd1)};
  endfunction

endpackage

FILE: rtl/qie_pix_if.sv
// Pixel input channel: valid/ready handshake with one RGBA pixel and frame flags.
// No dependencies.
interface qie_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       start_of_image;
  logic       end_of_image;

  modport source (
    output valid, red, green, blue, alpha, start_of_image, end_of_image,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha, start_of_image, end_of_image,
    output ready
  );
endinterface

FILE: rtl/qie_code_if.sv
// Code byte output channel: valid/ready handshake with one opcode stream byte.
// No dependencies.
interface qie_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_pixel;

  modport source (
    output valid, code_byte, last_of_pixel,
    input  ready
  );
  modport sink (
    input  valid, code_byte, last_of_pixel,
    output ready
  );
endinterface

FILE: rtl/qie_history.sv
// 64-entry pixel history: RAM with registered read, write forwarding, valid bits.
// Depends on qie_pkg and qoi_image_encoder_defines.svh.
`include "qoi_image_encoder_defines.svh"

module qie_history import qie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [HIST_AW-1:0] rd_addr_i,
  input  hist_wr_t           wr_i,
  input  logic [HIST_AW-1:0] lk_addr_i,
  output logic               lk_valid_o,
  output pixel_t             lk_data_o
);

  pixel_t                mem [HIST_DEPTH];
  pixel_t                rdata_q;
  pixel_t                fwd_data_q;
  logic                  fwd_q;
  logic [HIST_DEPTH-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      fwd_q      <= wr_i.we && (wr_i.addr == rd_addr_i);
      fwd_data_q <= wr_i.data;
    end
  end

  always_comb begin
    valid_d = wr_i.clr ? '0 : valid_q;
    if (wr_i.we) begin
      valid_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign lk_valid_o = valid_q[lk_addr_i];
  assign lk_data_o  = fwd_q ? fwd_data_q : rdata_q;

  // a new image leaves at most the one slot its first pixel wrote
  `QIE_ASSERT_NXT(a_clr_empties_hist, wr_i.clr, $countones(valid_q) <= 1)

endmodule

FILE: rtl/qie_encode.sv
// Encode stage: previous pixel and run state, opcode selection for one pixel.
// Depends on qie_pkg and qoi_image_encoder_defines.svh.
`include "qoi_image_encoder_defines.svh"

module qie_encode import qie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  pix_item_t          item_i,
  input  logic [HIST_AW-1:0] hash_i,
  input  logic               slot_valid_i,
  input  pixel_t             slot_data_i,
  output code_set_t          codes_o,
  output hist_wr_t           hist_o
);

  pixel_t                  prev_q, prev_eff;
  logic [5:0]              run_q, run_d, run_eff, run_inc;
  logic                    same, hit, flush_head;
  logic [OPS_MAX-1:0][7:0] ops;
  logic [CNT_W-1:0]        op_cnt;
  logic [7:0]              vr, vg, vb, dr, dg, db, lr, lg, lb;
  logic                    diff_ok, luma_ok;
  pixel_t                  px;

  assign px = item_i.px;

  always_comb begin
    prev_eff   = item_i.sof ? BLACK_PX : prev_q;
    run_eff    = item_i.sof ? 6'd0 : run_q;
    same       = (px == prev_eff);
    run_inc    = run_eff + 6'd1;
    flush_head = (run_q != 6'd0) && (item_i.sof || !same);
    // an unwritten slot reads as transparent black
    hit        = slot_valid_i ? (slot_data_i == px) : (px == '0);

    vr = px.r - prev_eff.r;
    vg = px.g - prev_eff.g;
    vb = px.b - prev_eff.b;
    dr = vr + 8'd2;
    dg = vg + 8'd2;
    db = vb + 8'd2;
    lr = vr - vg + 8'd8;
    lg = vg + 8'd32;
    lb = vb - vg + 8'd8;
    diff_ok = ((dr[7:2] | dg[7:2] | db[7:2]) == 6'd0);
    luma_ok = (lg[7:6] == 2'd0) && ((lr[7:4] | lb[7:4]) == 4'd0);

    ops    = '0;
    op_cnt = '0;
    run_d  = run_q;
    if (same) begin
      // run extended; flush at the limit or at end of image
      if (run_inc == RUN_LIMIT || item_i.eof) begin
        ops[0] = run_byte(run_inc);
        op_cnt = CNT_W'(1);
        run_d  = 6'd0;
      end else begin
        run_d  = run_inc;
      end
    end else begin
      run_d = 6'd0;
      if (hit) begin
        ops[0] = OP_INDEX | {2'b00, hash_i};
        op_cnt = CNT_W'(1);
      end else if (px.a == prev_eff.a) begin
        if (diff_ok) begin
          ops[0] = OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
          op_cnt = CNT_W'(1);
        end else if (luma_ok) begin
          ops[0] = OP_LUMA | {2'b00, lg[5:0]};
          ops[1] = {lr[3:0], lb[3:0]};
          op_cnt = CNT_W'(2);
        end else begin
          ops[0] = OP_RGB;
          ops[1] = px.r;
          ops[2] = px.g;
          ops[3] = px.b;
          op_cnt = CNT_W'(4);
        end
      end else begin
        ops[0] = OP_RGBA;
        ops[1] = px.r;
        ops[2] = px.g;
        ops[3] = px.b;
        ops[4] = px.a;
        op_cnt = CNT_W'(5);
      end
    end

    // pending run of the earlier pixels goes out ahead of this pixel's bytes
    if (flush_head) begin
      codes_o.bytes = {ops, run_byte(run_q)};
      codes_o.cnt   = op_cnt + CNT_W'(1);
    end else begin
      codes_o.bytes = {8'h00, ops};
      codes_o.cnt   = op_cnt;
    end

    hist_o.we   = fire_i && !same && !hit;
    hist_o.clr  = fire_i && item_i.sof;
    hist_o.addr = hash_i;
    hist_o.data = px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= BLACK_PX;
      run_q  <= 6'd0;
    end else if (fire_i) begin
      prev_q <= px;
      run_q  <= run_d;
    end
  end

  `QIE_ASSERT_IMP(a_run_below_limit, 1'b1, run_q < RUN_LIMIT)

endmodule

FILE: rtl/qie_out_buf.sv
// Result register: holds the bytes of one pixel and hands them out one a cycle while out_o.ready is high.
// Depends on qie_pkg, qie_code_if and qoi_image_encoder_defines.svh.
`include "qoi_image_encoder_defines.svh"

module qie_out_buf import qie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  code_set_t  codes_i,
  output logic       free_o,
  qie_code_if.source out_o
);

  logic [MAX_BYTES-1:0][7:0] bytes_q;
  logic [CNT_W-1:0]          cnt_q, idx_q;
  logic                      vld_q, last;

  assign last   = (idx_q == CNT_W'(cnt_q - CNT_W'(1)));
  assign free_o = !vld_q || (out_o.ready && last);

  assign out_o.valid         = vld_q;
  assign out_o.code_byte     = bytes_q[idx_q];
  assign out_o.last_of_pixel = last;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= codes_i.bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= (codes_i.cnt != '0);
      cnt_q <= codes_i.cnt;
      idx_q <= '0;
    end else if (vld_q && out_o.ready) begin
      if (last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  `QIE_ASSERT_IMP(a_idx_in_range, vld_q, (cnt_q != '0) && (idx_q < cnt_q))

endmodule

FILE: rtl/qoi_image_encoder.sv
// QOI encoder top level: pixel register, history, encode stage, result register.
// Depends on qie_pkg, qie_pix_if, qie_code_if, qie_history, qie_encode, qie_out_buf.
//
//  channel  dir  transaction                          payload
//  in_i     in   one RGBA pixel, raster order         red green blue alpha
//                                                     start_of_image end_of_image
//  out_o    out  one byte of the QOI opcode stream    code_byte last_of_pixel
//
// A pixel is taken into the pixel register while the history RAM read for its
// hash is issued; once the result register is free, the encode stage decides its
// bytes and loads them into the result register. A pixel yields no byte while a
// run goes on, 1 for a run end, index or diff, 2 for luma, and up to 6 when a run
// flush precedes an RGBA literal. The result register emits one byte per transaction.
// Reset clears the valid bits, run count and previous pixel (opaque black).
// Output stalls back up into the pixel register and then into in_i.ready.
`include "qoi_image_encoder_defines.svh"

module qoi_image_encoder import qie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qie_pix_if.sink    in_i,
  qie_code_if.source out_o
);

  pix_item_t          in_item;
  pix_item_t          pix_q;
  logic [HIST_AW-1:0] hash_in, hash_q;
  logic               pix_vld_q;
  logic               accept, fire, buf_free;
  logic               lk_valid;
  pixel_t             lk_data;
  hist_wr_t           hist_wr;
  code_set_t          codes;

  assign in_item.px.r = in_i.red;
  assign in_item.px.g = in_i.green;
  assign in_item.px.b = in_i.blue;
  assign in_item.px.a = in_i.alpha;
  assign in_item.sof  = in_i.start_of_image;
  assign in_item.eof  = in_i.end_of_image;
  assign hash_in      = qie_hash(in_item.px);

  // encode fires when a pixel is held and the result register is empty or empties this cycle
  assign fire       = pix_vld_q && buf_free;
  assign in_i.ready = !pix_vld_q || buf_free;
  assign accept     = in_i.valid && in_i.ready;

  // pixel register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= in_item;
      hash_q <= hash_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else if (accept) begin
      pix_vld_q <= 1'b1;
    end else if (fire) begin
      pix_vld_q <= 1'b0;
    end
  end

  // read issued with the accept; a same-edge write is forwarded inside
  qie_history u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (hash_in),
    .wr_i       (hist_wr),
    .lk_addr_i  (hash_q),
    .lk_valid_o (lk_valid),
    .lk_data_o  (lk_data)
  );

  // a start pixel sees an empty history
  qie_encode u_encode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (pix_q),
    .hash_i       (hash_q),
    .slot_valid_i (lk_valid && !pix_q.sof),
    .slot_data_i  (lk_data),
    .codes_o      (codes),
    .hist_o       (hist_wr)
  );

  qie_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .codes_i (codes),
    .free_o  (buf_free),
    .out_o   (out_o)
  );

  `QIE_ASSERT_NXT(a_bytes_presented, fire && (codes.cnt != '0), out_o.valid)
  `QIE_ASSERT_IMP(a_hist_write_on_fire, hist_wr.we || hist_wr.clr, fire)

endmodule
